// ===== rtl/point_hash_lookup_or_insert_defines.svh =====
// Assertion macros for the point hash lookup-or-insert block
`ifndef POINT_HASH_LOOKUP_OR_INSERT_DEFINES_SVH
`define POINT_HASH_LOOKUP_OR_INSERT_DEFINES_SVH
`ifndef SYNTHESIS
`define PH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PH_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define PH_ASSERT(label, clk, rst_n, prop)
`define PH_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/phli_pkg.sv =====
// Shared types and constants for the point hash lookup-or-insert block
`default_nettype none
package phli_pkg;
  localparam int BUCKETS    = 1024;
  localparam int ENTRIES    = 4096;
  localparam int COORD_BITS = 16;
  localparam int BKT_BITS   = $clog2(BUCKETS);
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int NUM_BITS   = $clog2(ENTRIES + 1);
  localparam int CNT_BITS   = 11;
  localparam logic [31:0] GOLDEN_FIX = 32'h9E3779B9;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
  } in_word_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] node_number;
    logic                created;
    logic                full_res;
  } out_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
    logic [BKT_BITS-1:0]   bucket;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/phli_front.sv =====
// Front end: Cantor key, multiplicative hash and bucket selection, pipelined
`default_nettype none
module phli_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [phli_pkg::CNT_BITS-1:0] bucket_count,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire phli_pkg::in_word_t          in_data,
  output logic                             job_valid,
  input  wire logic                        job_stall,
  output phli_pkg::job_t                   job_data
);
  localparam int CB = phli_pkg::COORD_BITS;
  localparam int SB = CB + 1;
  localparam int BB = phli_pkg::BKT_BITS;
  localparam int CNT_BITS_L = phli_pkg::CNT_BITS;

  // stage registers
  logic          v1_r, v2_r, v3_r, v4_r;
  logic [CB-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  logic [SB-1:0] a1_r, b1_r;
  logic [31:0]   key2_r, frac3_r;
  logic [BB-1:0] bkt4_r;
  logic          adv;
  logic [SB-1:0] s, a_nxt, b_nxt;
  logic [2*SB-1:0] tri_w;
  logic [63:0]   fprod;
  logic [42:0]   bprod;
  logic [CNT_BITS_L-1:0] bc_sat;
  logic [BB:0]   bfull;

  assign adv      = !(v4_r && job_stall);
  assign in_stall = !adv;

  // split the triangle product into its even half and odd factor
  always_comb begin
    s = SB'(in_data.x_coord) + SB'(in_data.y_coord);
    if (!s[0]) begin
      a_nxt = s >> 1;
      b_nxt = s + SB'(1);
    end else begin
      a_nxt = s;
      b_nxt = (s + SB'(1)) >> 1;
    end
    tri_w  = a1_r * b1_r;
    fprod  = key2_r * phli_pkg::GOLDEN_FIX;
    bc_sat = (bucket_count > CNT_BITS_L'(phli_pkg::BUCKETS)) ?
             CNT_BITS_L'(phli_pkg::BUCKETS) : bucket_count;
    bprod  = frac3_r * 43'(bc_sat);
    bfull  = (BB+1)'(bprod[42:32]);
    if (bprod[42:32] >= 11'(phli_pkg::BUCKETS)) bfull = (BB+1)'(phli_pkg::BUCKETS - 1);
  end

  // advance the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r <= in_data.x_coord; y1_r <= in_data.y_coord;
      a1_r <= a_nxt; b1_r <= b_nxt;
      x2_r <= x1_r; y2_r <= y1_r;
      key2_r <= 32'(tri_w) + 32'(y1_r);
      x3_r <= x2_r; y3_r <= y2_r;
      frac3_r <= fprod[31:0];
      x4_r <= x3_r; y4_r <= y3_r;
      bkt4_r <= bfull[BB-1:0];
    end
  end

  assign job_valid = v4_r;
  assign job_data  = '{x_coord: x4_r, y_coord: y4_r, bucket: bkt4_r};
endmodule
`default_nettype wire

// ===== rtl/phli_queue.sv =====
// Short queue between the hashing front end and the chain walker
`default_nettype none
module phli_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_stall,
  input  wire phli_pkg::job_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_stall,
  output phli_pkg::job_t      rd_data
);
  localparam int DEPTH = 4;
  localparam int PB = $clog2(DEPTH);
  phli_pkg::job_t mem_r [DEPTH];
  logic [PB-1:0] wp_r, rp_r;
  logic [PB:0] cnt_r;
  logic push, pop;

  assign wr_stall = (cnt_r == (PB+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  // store incoming word
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PB'(1);
      if (pop)  rp_r <= rp_r + PB'(1);
      cnt_r <= cnt_r + (PB+1)'(push) - (PB+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/phli_back.sv =====
// Back end: walk the bucket chain in memory, insert on miss, hold the result
`default_nettype none
`include "point_hash_lookup_or_insert_defines.svh"
module phli_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_stall,
  input  wire phli_pkg::job_t job_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output phli_pkg::out_word_t out_data
);
  localparam int BB = phli_pkg::BKT_BITS;
  localparam int IB = phli_pkg::IDX_BITS;
  localparam int NB = phli_pkg::NUM_BITS;
  localparam int CB = phli_pkg::COORD_BITS;
  localparam int EW = 2*CB + NB;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [NB-1:0] head_mem [phli_pkg::BUCKETS];
  logic [EW-1:0] ent_mem  [phli_pkg::ENTRIES];

  logic [2:0]    st_r, st_nxt;
  logic [BB:0]   clr_r, clr_nxt;
  logic [NB-1:0] next_r, next_nxt, cur_r, cur_nxt, head_rd_r;
  logic [EW-1:0] ent_rd_r;
  logic [NB-1:0] hd_r, hd_nxt;
  phli_pkg::job_t job_r, job_nxt;
  phli_pkg::out_word_t res_r, res_nxt;
  logic          ov_r, ov_nxt;
  logic          h_we, e_we;
  logic [BB-1:0] h_wa, h_ra;
  logic [NB-1:0] h_wd;
  logic [IB-1:0] e_a;
  logic [EW-1:0] e_wd;
  logic [NB-1:0] lnk;
  logic          hit, take;

  assign take      = (st_r == S_IDLE) && job_valid && (!ov_r || !out_stall);
  assign job_stall = !take;
  assign lnk       = ent_rd_r[NB-1:0];
  assign hit = (ent_rd_r[EW-1 -: CB] == job_r.x_coord) &&
               (ent_rd_r[EW-1-CB -: CB] == job_r.y_coord);

  // sequence the walk
  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; next_nxt = next_r; cur_nxt = cur_r;
    hd_nxt = hd_r; job_nxt = job_r; res_nxt = res_r; ov_nxt = ov_r;
    h_we = 1'b0; h_wa = job_r.bucket; h_wd = '0; h_ra = job_data.bucket;
    e_we = 1'b0; e_a = IB'(cur_r - NB'(1));
    e_wd = {job_r.x_coord, job_r.y_coord, hd_r};
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_CLEAR: begin
        h_we = 1'b1; h_wa = clr_r[BB-1:0];
        clr_nxt = clr_r + (BB+1)'(1);
        if (clr_r == (BB+1)'(phli_pkg::BUCKETS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: if (take) begin
        job_nxt = job_data; st_nxt = S_HEAD;
      end
      S_HEAD: begin
        hd_nxt = head_rd_r; cur_nxt = head_rd_r;
        st_nxt = (head_rd_r == '0) ? S_DONE : S_READ;
      end
      S_READ: st_nxt = S_CMP;
      S_CMP: begin
        if (hit) begin
          res_nxt = '{node_number: cur_r, created: 1'b0, full_res: 1'b0};
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          cur_nxt = lnk;
          st_nxt = (lnk == '0) ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        if (next_r > NB'(phli_pkg::ENTRIES)) begin
          res_nxt = '{node_number: '0, created: 1'b0, full_res: 1'b1};
        end else begin
          h_we = 1'b1; h_wd = next_r;
          e_we = 1'b1; e_a = IB'(next_r - NB'(1));
          next_nxt = next_r + NB'(1);
          res_nxt = '{node_number: next_r, created: 1'b1, full_res: 1'b0};
        end
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (h_we) head_mem[h_wa] <= h_wd;
    head_rd_r <= head_mem[h_ra];
  end
  always_ff @(posedge clk) begin
    if (e_we) ent_mem[e_a] <= e_wd;
    ent_rd_r <= ent_mem[e_a];
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; next_r <= NB'(1); ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; next_r <= next_nxt; ov_r <= ov_nxt;
    end
  end
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; hd_r <= hd_nxt; job_r <= job_nxt; res_r <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

  `PH_ASSERT(a_res_onehot, clk, rst_n, !(ov_r && res_r.created && res_r.full_res))
  `PH_ASSERT_NEXT(a_take_clears_result, clk, rst_n, take, !ov_r)
  `PH_ASSERT_NEXT(a_insert_bumps, clk, rst_n, e_we, next_r == $past(next_r) + NB'(1))
endmodule
`default_nettype wire

// ===== rtl/point_hash_lookup_or_insert.sv =====
// Top level: hashing front end, job queue and chain walking back end
// A taken word passes the front stages and the job queue; the back end then reads its bucket head
// and walks the chain, reading and comparing each entry it visits, and inserts on a miss.
// The back end takes a new word only when idle with its result slot free; single entry port.
// After reset a clearing pass empties the bucket heads; up to 8 words wait then.
// Bucket count writes act at once and must come only while no word is in flight.
`default_nettype none
module point_hash_lookup_or_insert (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [phli_pkg::CNT_BITS-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire phli_pkg::in_word_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output phli_pkg::out_word_t                out_data
);
  logic [phli_pkg::CNT_BITS-1:0] bc_r;
  logic f_v, f_s, q_v, q_s;
  phli_pkg::job_t f_d, q_d;

  // hold bucket count register
  always_ff @(posedge clk) begin
    if (!rst_n) bc_r <= phli_pkg::CNT_BITS'(phli_pkg::BUCKETS);
    else if (cfg_we) bc_r <= cfg_wdata;
  end

  phli_front u_front (.clk, .rst_n, .bucket_count(bc_r), .in_valid, .in_stall,
    .in_data, .job_valid(f_v), .job_stall(f_s), .job_data(f_d));
  phli_queue u_queue (.clk, .rst_n, .wr_valid(f_v), .wr_stall(f_s), .wr_data(f_d),
    .rd_valid(q_v), .rd_stall(q_s), .rd_data(q_d));
  phli_back u_back (.clk, .rst_n, .job_valid(q_v), .job_stall(q_s), .job_data(q_d),
    .out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the point hash lookup-or-insert block: predictor, scoreboard and stimulus
`timescale 1ns / 1ps
module tb;

  // Scoreboard: predicts node numbers from its own hash table copy
  class node_table_board;
    logic [phli_pkg::NUM_BITS-1:0]   heads [phli_pkg::BUCKETS];
    logic [phli_pkg::COORD_BITS-1:0] px [phli_pkg::ENTRIES];
    logic [phli_pkg::COORD_BITS-1:0] py [phli_pkg::ENTRIES];
    logic [phli_pkg::NUM_BITS-1:0]   links [phli_pkg::ENTRIES];
    logic [phli_pkg::NUM_BITS-1:0]   next_num;
    logic [phli_pkg::CNT_BITS-1:0]   bkt_count;
    phli_pkg::out_word_t             pending [$];
    int                              mismatches;
    int                              checked;
    int                              inserts;
    int                              founds;
    int                              fulls;

    function new();
      foreach (heads[i]) heads[i] = '0;
      next_num = 1;
      bkt_count = 11'd1024;
      mismatches = 0;
      checked = 0;
      inserts = 0;
      founds = 0;
      fulls = 0;
    endfunction

    function void set_count(logic [phli_pkg::CNT_BITS-1:0] v);
      bkt_count = v;
    endfunction

    function logic [phli_pkg::BKT_BITS-1:0] bucket_for(logic [phli_pkg::COORD_BITS-1:0] x,
                                                       logic [phli_pkg::COORD_BITS-1:0] y);
      logic [63:0] s;
      logic [63:0] tri_n;
      logic [31:0] key;
      logic [31:0] frac;
      logic [63:0] prod;
      logic [63:0] bc;
      s = 64'(x) + 64'(y);
      tri_n = s[0] ? s * ((s + 1) >> 1) : (s >> 1) * (s + 1);
      key = 32'(tri_n + 64'(y));
      frac = 32'(64'(key) * 64'(phli_pkg::GOLDEN_FIX));
      bc = (bkt_count > phli_pkg::BUCKETS) ? 64'(phli_pkg::BUCKETS) : 64'(bkt_count);
      prod = (64'(frac) * bc) >> 32;
      if (prod >= phli_pkg::BUCKETS) prod = phli_pkg::BUCKETS - 1;
      return prod[phli_pkg::BKT_BITS-1:0];
    endfunction

    // Note an accepted point and queue its expected word
    function void note_point(phli_pkg::in_word_t w);
      logic [phli_pkg::BKT_BITS-1:0] b;
      logic [phli_pkg::NUM_BITS-1:0] n;
      phli_pkg::out_word_t r;
      b = bucket_for(w.x_coord, w.y_coord);
      n = heads[b];
      r = '0;
      while (n != 0) begin
        if (px[n-1] == w.x_coord && py[n-1] == w.y_coord) break;
        n = links[n-1];
      end
      if (n != 0) begin
        r.node_number = n;
        founds++;
      end else if (next_num > phli_pkg::ENTRIES) begin
        r.full_res = 1'b1;
        fulls++;
      end else begin
        px[next_num-1] = w.x_coord;
        py[next_num-1] = w.y_coord;
        links[next_num-1] = heads[b];
        heads[b] = next_num;
        r.node_number = next_num;
        r.created = 1'b1;
        next_num++;
        inserts++;
      end
      pending.push_back(r);
    endfunction

    // Check one result word against the oldest expectation
    function void check_word(phli_pkg::out_word_t got);
      phli_pkg::out_word_t exp_w;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.node_number !== exp_w.node_number || got.created !== exp_w.created ||
          got.full_res !== exp_w.full_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected node %0d created %0b full %0b, got %0d %0b %0b",
                   exp_w.node_number, exp_w.created, exp_w.full_res,
                   got.node_number, got.created, got.full_res);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [phli_pkg::CNT_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  phli_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  phli_pkg::out_word_t out_data;

  node_table_board board = new();
  logic idle_on = 1'b1;
  longint cycles = 0;
  phli_pkg::in_word_t seen [$];

  point_hash_lookup_or_insert DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Watchdog on total cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Note accepted points and check accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_point(in_data);
    if (rst_n && out_valid && !out_stall) board.check_word(out_data);
  end

  // Receiver stalls in random bursts while idling is on
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Send one word, holding it until taken
  task automatic send_point(logic [15:0] x, logic [15:0] y);
    phli_pkg::in_word_t w;
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.x_coord = x;
    w.y_coord = y;
    in_valid <= 1'b1;
    in_data <= w;
    seen.push_back(w);
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every expected word, then some settling
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_count(logic [phli_pkg::CNT_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_count(v);
  endtask

  // Random points: fresh ones over a small or full range, plus repeats
  task automatic random_points(int n, int span);
    phli_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      if (seen.size() > 0 && $urandom_range(0, 2) == 0) begin
        w = seen[$urandom_range(0, seen.size() - 1)];
        send_point(w.x_coord, w.y_coord);
      end else if ($urandom_range(0, 3) == 0)
        send_point(16'($urandom), 16'($urandom));
      else
        send_point(16'($urandom_range(0, span)), 16'($urandom_range(0, span)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, found, zero and single bucket, saturation
    send_point(16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'hFFFF, 16'h0000);
    send_point(16'h0000, 16'hFFFF);
    send_point(16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'h5555, 16'hAAAA);
    send_point(16'hAAAA, 16'h5555);
    drain();
    write_count(11'd0);
    send_point(16'd1, 16'd2);
    send_point(16'd3, 16'd4);
    send_point(16'd1, 16'd2);
    send_point(16'h0000, 16'h0000);
    drain();
    write_count(11'd1);
    send_point(16'd7, 16'd9);
    send_point(16'd3, 16'd4);
    send_point(16'd7, 16'd9);
    drain();
    write_count(11'd2047);
    send_point(16'd1, 16'd2);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'd100, 16'd200);
    drain();

    // Random phases under several bucket counts
    write_count(11'd1024);
    random_points(100, 63);
    drain();
    write_count(11'd3);
    random_points(60, 15);
    drain();
    write_count(11'($urandom_range(1, 1024)));
    random_points(80, 255);
    drain();
    write_count(11'd1025);
    random_points(80, 1023);
    drain();

    // Last phase back to back, without idling on either side
    idle_on = 1'b0;
    write_count(11'd1024);
    random_points(60, 4095);
    drain();

    $display("Checked %0d words: %0d inserts, %0d finds, %0d full; bucket counts 0 to 2047.",
             board.checked, board.inserts, board.founds, board.fulls);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
